>>> src/b2f_pkg.sv
// Shared types, constants and widths for the base-to-flowgram converter.
package b2f_pkg;

    localparam int FLOW_CAP      = 1024;
    localparam int MAX_ORDER_LEN = 32;

    localparam int ORDER_W = 2 * MAX_ORDER_LEN;
    localparam int LEN_W   = $clog2(MAX_ORDER_LEN + 1);
    localparam int POS_W   = $clog2(MAX_ORDER_LEN);
    localparam int LIM_W   = $clog2(FLOW_CAP + 1);
    localparam int FLOW_W  = 10;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 64;
    localparam int CIDX_W  = 2;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_FLOW_ORDER     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FLOW_ORDER_LEN = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_NUM_FLOWS      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] RST_FLOW_ORDER     = 64'd0;
    localparam logic [5:0]       RST_FLOW_ORDER_LEN = 6'd4;
    localparam logic [10:0]      RST_NUM_FLOWS      = 11'd400;

    // Result status codes
    localparam logic [1:0] ST_NORMAL    = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_ABSENT    = 2'd2;

    typedef struct packed {
        logic [1:0] base;
        logic       last_base;
    } base_beat_t;

    typedef struct packed {
        logic [FLOW_W-1:0]  flow_index;
        logic [COUNT_W-1:0] base_count;
        logic [1:0]         status;
        logic               end_of_read;
    } flow_beat_t;

    // Classified base as it waits between front and back
    typedef struct packed {
        logic [1:0] base;
        logic       last_base;
        logic       found;
    } qent_t;

    // Effective configuration, already clamped to range
    typedef struct packed {
        logic [ORDER_W-1:0] flow_order;
        logic [LEN_W-1:0]   order_len;
        logic [LIM_W-1:0]   flow_limit;
    } cfg_t;

endpackage

>>> src/b2f_front.sv
// Front end: accepts bases and tags each with whether it occurs in the flow order.
module b2f_front
(
    input  logic                base_valid,
    output logic                base_stall,
    input  b2f_pkg::base_beat_t base_data,
    input  b2f_pkg::cfg_t       cfg,
    input  logic                q_full,
    output logic                q_push,
    output b2f_pkg::qent_t      q_entry
);

    logic found;

    // Search the active part of the order for the base
    always_comb
    begin
        found = 1'b0;
        for (int i = 0; i < b2f_pkg::MAX_ORDER_LEN; i++)
        begin
            if ((b2f_pkg::LEN_W'(i) < cfg.order_len) &&
                (cfg.flow_order[2*i +: 2] == base_data.base))
            begin
                found = 1'b1;
            end
        end
    end

    // Push while the queue has room
    assign base_stall        = q_full;
    assign q_push            = base_valid && !q_full;
    assign q_entry.base      = base_data.base;
    assign q_entry.last_base = base_data.last_base;
    assign q_entry.found     = found;

endmodule

>>> src/b2f_queue.sv
// Short queue of classified bases between the front and back ends.
module b2f_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b2f_pkg::qent_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output b2f_pkg::qent_t head_data
);

    b2f_pkg::qent_t                 mem_reg [b2f_pkg::QDEPTH];
    logic [b2f_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [b2f_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [b2f_pkg::QCNT_W-1:0]     count_reg;
    logic [b2f_pkg::QCNT_W-1:0]     count_next;
    logic                           do_pop;

    assign full       = (count_reg == b2f_pkg::QCNT_W'(b2f_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> src/b2f_back.sv
// Back end: walks flow order for the head base, up to one flow per free cycle.
module b2f_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  b2f_pkg::cfg_t       cfg,
    input  logic                head_valid,
    input  b2f_pkg::qent_t      head_data,
    output logic                pop,
    output logic                flow_valid,
    input  logic                flow_stall,
    output b2f_pkg::flow_beat_t flow_data
);

    logic [b2f_pkg::FLOW_W-1:0]  flow_reg,  flow_next;
    logic [b2f_pkg::POS_W-1:0]   pos_reg,   pos_next;
    logic [b2f_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        fin_reg,   fin_next;
    logic                        out_valid_reg;
    b2f_pkg::flow_beat_t         out_reg;

    logic [b2f_pkg::POS_W-1:0]   pos_n;
    logic [b2f_pkg::LEN_W-1:0]   pos_inc;
    logic [b2f_pkg::POS_W-1:0]   pos_adv;
    logic [b2f_pkg::LEN_W-1:0]   slot_idx;
    logic [b2f_pkg::COUNT_W-1:0] count_sat;
    logic [b2f_pkg::LIM_W-1:0]   flow_wide;
    logic                        match;
    logic                        emit;
    logic                        done;
    logic                        out_free;
    logic                        advance;
    b2f_pkg::flow_beat_t         beat;

    // Normalise the stored slot and find the one after it
    assign pos_n     = ({1'b0, pos_reg} >= cfg.order_len) ? '0 : pos_reg;
    assign pos_inc   = {1'b0, pos_n} + 1'b1;
    assign pos_adv   = (pos_inc >= cfg.order_len) ? '0 : pos_inc[b2f_pkg::POS_W-1:0];
    assign slot_idx  = {pos_n, 1'b0};
    assign match     = (cfg.flow_order[slot_idx +: 2] == head_data.base);
    assign count_sat = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign flow_wide = b2f_pkg::LIM_W'(flow_reg);

    // Decide one step for the head base
    always_comb
    begin
        flow_next        = flow_reg;
        pos_next         = pos_reg;
        count_next       = count_reg;
        fin_next         = fin_reg;
        emit             = 1'b0;
        done             = 1'b1;
        beat.flow_index  = flow_reg;
        beat.base_count  = count_reg;
        beat.status      = b2f_pkg::ST_NORMAL;
        beat.end_of_read = 1'b1;
        if (fin_reg)
        begin
            // drop bases until the read closes
            if (head_data.last_base)
            begin
                flow_next  = '0;
                pos_next   = '0;
                count_next = '0;
                fin_next   = 1'b0;
            end
        end
        else if ((flow_wide >= cfg.flow_limit) || !head_data.found ||
                 (!match && (flow_wide + 1'b1 >= cfg.flow_limit)))
        begin
            // end the read early
            emit        = 1'b1;
            beat.status = head_data.found ? b2f_pkg::ST_EXHAUSTED : b2f_pkg::ST_ABSENT;
            if (flow_wide >= cfg.flow_limit)
            begin
                beat.status = b2f_pkg::ST_EXHAUSTED;
            end
            if (head_data.last_base)
            begin
                flow_next  = '0;
                pos_next   = '0;
                count_next = '0;
                fin_next   = 1'b0;
            end
            else
            begin
                pos_next = pos_n;
                fin_next = 1'b1;
            end
        end
        else if (match)
        begin
            // place the base in the current flow
            beat.base_count = count_sat;
            if (head_data.last_base)
            begin
                emit       = 1'b1;
                flow_next  = '0;
                pos_next   = '0;
                count_next = '0;
            end
            else
            begin
                pos_next   = pos_n;
                count_next = count_sat;
            end
        end
        else
        begin
            // close the current flow and move on
            emit             = 1'b1;
            done             = 1'b0;
            beat.end_of_read = 1'b0;
            flow_next        = flow_reg + 1'b1;
            pos_next         = pos_adv;
            count_next       = '0;
        end
    end

    assign out_free   = !out_valid_reg || !flow_stall;
    assign advance    = head_valid && (!emit || out_free);
    assign pop        = advance && done;
    assign flow_valid = out_valid_reg;
    assign flow_data  = out_reg;

    // Hold the read state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_reg  <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
            fin_reg   <= 1'b0;
        end
        else if (advance)
        begin
            flow_reg  <= flow_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            fin_reg   <= fin_next;
        end
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!flow_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= beat;
        end
    end

endmodule

>>> src/base_to_flowgram_converter_top.sv
// Top level of the base-to-flowgram converter: configuration, front, queue and back.
// With the back end idle, an accepted base is written into the queue and becomes its head;
// the back end decides it there and registers its first flow beat in the output register.
// The back end takes one step per base plus one per flow it passes over, set by the single
// flow-stepping unit and held by output stalls; the four-entry queue absorbs the difference.
// Reset: clears read state, empties the queue and restores configuration defaults.
module base_to_flowgram_converter_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [b2f_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [b2f_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         base_valid,
    output logic                         base_stall,
    input  b2f_pkg::base_beat_t          base_data,
    output logic                         flow_valid,
    input  logic                         flow_stall,
    output b2f_pkg::flow_beat_t          flow_data
);

    logic [b2f_pkg::ORDER_W-1:0] order_reg;
    logic [5:0]                  len_reg;
    logic [10:0]                 nflows_reg;
    b2f_pkg::cfg_t               cfg;
    logic                        q_full;
    logic                        q_push;
    logic                        q_pop;
    logic                        head_valid;
    b2f_pkg::qent_t              q_entry;
    b2f_pkg::qent_t              head_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg  <= b2f_pkg::RST_FLOW_ORDER;
            len_reg    <= b2f_pkg::RST_FLOW_ORDER_LEN;
            nflows_reg <= b2f_pkg::RST_NUM_FLOWS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                b2f_pkg::CFG_FLOW_ORDER:     order_reg  <= cfg_data;
                b2f_pkg::CFG_FLOW_ORDER_LEN: len_reg    <= cfg_data[5:0];
                b2f_pkg::CFG_NUM_FLOWS:      nflows_reg <= cfg_data[10:0];
                default:                     ;
            endcase
        end
    end

    // Clamp cycle length and flow budget into range
    always_comb
    begin
        cfg.flow_order = order_reg;
        if (len_reg == '0)
        begin
            cfg.order_len = b2f_pkg::LEN_W'(1);
        end
        else if (len_reg > 6'(b2f_pkg::MAX_ORDER_LEN))
        begin
            cfg.order_len = b2f_pkg::LEN_W'(b2f_pkg::MAX_ORDER_LEN);
        end
        else
        begin
            cfg.order_len = b2f_pkg::LEN_W'(len_reg);
        end
        if (nflows_reg == '0)
        begin
            cfg.flow_limit = b2f_pkg::LIM_W'(1);
        end
        else if (nflows_reg > 11'(b2f_pkg::FLOW_CAP))
        begin
            cfg.flow_limit = b2f_pkg::LIM_W'(b2f_pkg::FLOW_CAP);
        end
        else
        begin
            cfg.flow_limit = b2f_pkg::LIM_W'(nflows_reg);
        end
    end

    b2f_front u_front
    (
        .base_valid (base_valid),
        .base_stall (base_stall),
        .base_data  (base_data),
        .cfg        (cfg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    b2f_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    b2f_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (q_pop),
        .flow_valid (flow_valid),
        .flow_stall (flow_stall),
        .flow_data  (flow_data)
    );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the base-to-flowgram converter top level.
module tb;
    import b2f_pkg::*;

    // Nucleotide codes
    localparam logic [1:0] NUC_A = 2'd0;
    localparam logic [1:0] NUC_C = 2'd1;
    localparam logic [1:0] NUC_G = 2'd2;
    localparam logic [1:0] NUC_T = 2'd3;

    // Flow orders used by the directed rows and the fixed phases
    localparam logic [CFG_W-1:0] ORDER_ACGT     = 64'hE4E4_E4E4_E4E4_E4E4;
    localparam logic [CFG_W-1:0] ORDER_G_THEN_T = 64'hFFFF_FFFF_FFFF_FFFE;
    localparam logic [CFG_W-1:0] ORDER_T_AT_END = 64'hC000_0000_0000_0000;

    localparam int ITEM_TARGET    = 470;
    localparam int PHASE_BASES    = 45;
    localparam int SWEEP_BASES    = 70;
    localparam int HOMOPOLYMER    = 260;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;
    // Longest quiet stretch of a good run is the long receiver hold; allow well over it
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic              is_write;
        logic [CIDX_W-1:0] idx;
        logic [CFG_W-1:0]  val;
        logic [1:0]        base;
        logic              last;
        logic              typed;
        flow_beat_t        res;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              base_valid;
    logic              base_stall;
    base_beat_t        base_data;
    logic              flow_valid;
    logic              flow_stall;
    flow_beat_t        flow_data;

    // Predictor copy of the registers and the read state
    logic [CFG_W-1:0] order_r;
    logic [5:0]       order_len_r;
    logic [10:0]      flow_budget_r;
    int unsigned      cur_flow;
    int unsigned      cur_slot;
    int unsigned      cur_count;
    bit               read_done;

    flow_beat_t expected_flows[$];
    plan_row_t  plan[$];
    int         errors;
    int         live_bases;
    int         beats_seen;
    int         quiet_cycles;
    bit         calm;

    base_to_flowgram_converter_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .base_valid (base_valid),
        .base_stall (base_stall),
        .base_data  (base_data),
        .flow_valid (flow_valid),
        .flow_stall (flow_stall),
        .flow_data  (flow_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int unsigned order_span();
        if (order_len_r == 0)
            return 1;
        if (order_len_r > MAX_ORDER_LEN)
            return MAX_ORDER_LEN;
        return order_len_r;
    endfunction

    function automatic int unsigned flow_budget();
        if (flow_budget_r == 0)
            return 1;
        if (flow_budget_r > FLOW_CAP)
            return FLOW_CAP;
        return flow_budget_r;
    endfunction

    function automatic logic [1:0] nuc_at(input int unsigned slot);
        return order_r[2 * (slot % 32) +: 2];
    endfunction

    task automatic clear_read_state();
        cur_flow  = 0;
        cur_slot  = 0;
        cur_count = 0;
        read_done = 1'b0;
    endtask

    task automatic push_flow(input int unsigned f, input int unsigned c,
                             input logic [1:0] st, input logic eor);
        flow_beat_t beat;
        beat.flow_index  = f[FLOW_W-1:0];
        beat.base_count  = c[COUNT_W-1:0];
        beat.status      = st;
        beat.end_of_read = eor;
        expected_flows.insert(expected_flows.size(), beat);
    endtask

    // Early end: park the read until its last base, or drop it at once
    task automatic close_read(input logic last, input int unsigned f,
                              input int unsigned p, input int unsigned c);
        if (last)
            clear_read_state();
        else
        begin
            cur_flow  = f;
            cur_slot  = p;
            cur_count = c;
            read_done = 1'b1;
        end
    endtask

    // Place one base in flow space and queue the flow beats it closes
    task automatic predict_flows(input logic [1:0] b, input logic last);
        int unsigned span;
        int unsigned budget;
        int unsigned f;
        int unsigned p;
        int unsigned c;
        int unsigned i;
        bit          found;
        found = 1'b0;
        if (read_done)
        begin
            if (last)
                clear_read_state();
            return;
        end
        span   = order_span();
        budget = flow_budget();
        f      = cur_flow;
        p      = (cur_slot >= span) ? 0 : cur_slot;
        c      = cur_count;
        if (f >= budget)
        begin
            push_flow(f, c, ST_EXHAUSTED, 1'b1);
            close_read(last, f, p, c);
            return;
        end
        for (i = 0; i < span; i++)
            if (nuc_at(i) == b)
                found = 1'b1;
        if (!found)
        begin
            push_flow(f, c, ST_ABSENT, 1'b1);
            close_read(last, f, p, c);
            return;
        end
        // Step past flows whose nucleotide differs, reporting each
        for (i = 0; i < span && nuc_at(p) != b; i++)
        begin
            if (f + 1 >= budget)
            begin
                push_flow(f, c, ST_EXHAUSTED, 1'b1);
                close_read(last, f, p, c);
                return;
            end
            push_flow(f, c, ST_NORMAL, 1'b0);
            f++;
            c = 0;
            p = (p + 1 >= span) ? 0 : p + 1;
        end
        c = (c < 255) ? c + 1 : 255;
        if (last)
        begin
            push_flow(f, c, ST_NORMAL, 1'b1);
            clear_read_state();
        end
        else
        begin
            cur_flow  = f;
            cur_slot  = p;
            cur_count = c;
        end
    endtask

    task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_FLOW_ORDER:     order_r = val;
            CFG_FLOW_ORDER_LEN: order_len_r = val[5:0];
            CFG_NUM_FLOWS:      flow_budget_r = val[10:0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one base beat after a random gap, none when calm, and predict once it is taken
    task automatic send_base(input logic [1:0] b, input logic last,
                             input logic typed, input flow_beat_t res);
        int         gap;
        int         queued;
        base_beat_t beat;
        gap            = calm ? 0 : $urandom_range(0, 8);
        beat.base      = b;
        beat.last_base = last;
        @(negedge clk);
        if (gap > 0)
        begin
            base_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        base_valid <= 1'b1;
        base_data  <= beat;
        do
            @(posedge clk);
        while (base_stall);
        live_bases++;
        queued = expected_flows.size();
        predict_flows(b, last);
        // A typed row replaces the predicted beat by the one written in the plan
        if (typed)
        begin
            while (expected_flows.size() > queued)
                void'(expected_flows.pop_back());
            expected_flows.insert(expected_flows.size(), res);
        end
    endtask

    // Hold the input idle until every flow beat is in, then let the back end empty
    task automatic settle();
        @(negedge clk);
        base_valid <= 1'b0;
        while (expected_flows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_read();
        int         n;
        int         k;
        bit         broken;
        logic [1:0] b;
        n      = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
        broken = ($urandom_range(0, 9) == 0);
        b      = NUC_A;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                b = 2'($urandom_range(0, 3));
            else if (k == 0 || $urandom_range(0, 2) != 0)
                b = nuc_at($urandom_range(0, order_span() - 1));
            send_base(b, (k == n - 1) && !broken, 1'b0, '0);
        end
    endtask

    task automatic plan_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        plan_row_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.idx      = idx;
        row.val      = val;
        plan.insert(plan.size(), row);
    endtask

    task automatic plan_base(input logic [1:0] b, input logic last);
        plan_row_t row;
        row      = '0;
        row.base = b;
        row.last = last;
        plan.insert(plan.size(), row);
    endtask

    // Rows whose single beat always ends the read
    task automatic plan_typed(input logic [1:0] b, input logic last, input int unsigned f,
                              input int unsigned c, input logic [1:0] st);
        plan_row_t row;
        row                 = '0;
        row.base            = b;
        row.last            = last;
        row.typed           = 1'b1;
        row.res.flow_index  = f[FLOW_W-1:0];
        row.res.base_count  = c[COUNT_W-1:0];
        row.res.status      = st;
        row.res.end_of_read = 1'b1;
        plan.insert(plan.size(), row);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Flow sink: random stalls per beat, one long hold to back the block up
    initial
    begin : flow_sink
        int         wait_cycles;
        flow_beat_t got;
        flow_beat_t want;
        flow_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats_seen == HOLD_AT)
                wait_cycles = HOLD_CYCLES;
            else
                wait_cycles = calm ? 0 : $urandom_range(0, 8);
            @(negedge clk);
            if (wait_cycles > 0)
            begin
                flow_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            flow_stall <= 1'b0;
            do
                @(posedge clk);
            while (!flow_valid);
            got = flow_data;
            beats_seen++;
            if (expected_flows.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected flow beat: index %0d count %0d status %0d end %0b",
                         $time, got.flow_index, got.base_count, got.status, got.end_of_read);
            end
            else
            begin
                want = expected_flows.pop_front();
                check_field("flow_index", want.flow_index, got.flow_index);
                check_field("base_count", want.base_count, got.base_count);
                check_field("status", want.status, got.status);
                check_field("end_of_read", want.end_of_read, got.end_of_read);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (base_valid && !base_stall) || (flow_valid && !flow_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("base_to_flowgram_converter_top regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int          r;
        int          phase;
        int          k;
        int          start;
        logic [1:0]  b;
        logic [CFG_W-1:0] order_pick;
        logic [CFG_W-1:0] len_pick;
        logic [CFG_W-1:0] budget_pick;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        base_valid    = 1'b0;
        base_data     = '0;
        errors        = 0;
        live_bases    = 0;
        beats_seen    = 0;
        quiet_cycles  = 0;
        calm          = 1'b0;
        order_r       = RST_FLOW_ORDER;
        order_len_r   = RST_FLOW_ORDER_LEN;
        flow_budget_r = RST_NUM_FLOWS;
        clear_read_state();

        // Directed rows: reset settings first, then budget, span and slot corners
        plan_typed(NUC_C, 1'b0, 0, 0, ST_ABSENT);
        plan_base(NUC_A, 1'b0);
        plan_base(NUC_T, 1'b1);
        plan_typed(NUC_A, 1'b1, 0, 1, ST_NORMAL);
        plan_write(CFG_FLOW_ORDER, ORDER_ACGT);
        plan_base(NUC_T, 1'b0);
        plan_base(NUC_T, 1'b0);
        plan_base(NUC_A, 1'b1);
        plan_write(CFG_NUM_FLOWS, 64'd0);
        plan_typed(NUC_C, 1'b0, 0, 0, ST_EXHAUSTED);
        plan_base(NUC_C, 1'b1);
        plan_base(NUC_A, 1'b0);
        plan_typed(NUC_C, 1'b1, 0, 1, ST_EXHAUSTED);
        plan_write(CFG_NUM_FLOWS, 64'd2047);
        plan_write(CFG_FLOW_ORDER_LEN, 64'd0);
        plan_base(NUC_A, 1'b0);
        plan_base(NUC_A, 1'b0);
        plan_typed(NUC_C, 1'b1, 0, 2, ST_ABSENT);
        plan_write(CFG_FLOW_ORDER, ORDER_G_THEN_T);
        plan_write(CFG_FLOW_ORDER_LEN, 64'd63);
        plan_base(NUC_T, 1'b0);
        plan_base(NUC_G, 1'b0);
        plan_typed(NUC_A, 1'b1, 32, 1, ST_ABSENT);
        plan_base(NUC_T, 1'b0);
        // shrink the cycle under an open read: its slot falls back to the start
        plan_write(CFG_FLOW_ORDER_LEN, 64'd1);
        plan_typed(NUC_G, 1'b1, 1, 2, ST_NORMAL);
        plan_write(CFG_FLOW_ORDER_LEN, 64'd32);
        plan_base(NUC_T, 1'b0);
        // cut the budget below the open read's flow
        plan_write(CFG_NUM_FLOWS, 64'd1);
        plan_typed(NUC_A, 1'b0, 1, 1, ST_EXHAUSTED);
        plan_base(NUC_A, 1'b1);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < plan.size(); r++)
        begin
            if (plan[r].is_write)
            begin
                settle();
                cfg_write(plan[r].idx, plan[r].val);
            end
            else
                send_base(plan[r].base, plan[r].last, plan[r].typed, plan[r].res);
        end

        // Random phases: sweep to the last flow, a long homopolymer, then mixed reads
        phase = 0;
        while (phase < 2 || live_bases < ITEM_TARGET)
        begin
            settle();
            if (phase == 0)
            begin
                order_pick  = ORDER_T_AT_END;
                len_pick    = 64'd32;
                budget_pick = 64'(FLOW_CAP);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       order_pick = {$urandom, $urandom};
                    1:       order_pick = {32{2'($urandom_range(0, 3))}};
                    2:       order_pick = ORDER_ACGT;
                    default: order_pick = ~{$urandom, $urandom};
                endcase
                case ($urandom_range(0, 5))
                    0:       len_pick = 64'd0;
                    1:       len_pick = 64'd1;
                    2:       len_pick = 64'(MAX_ORDER_LEN);
                    3:       len_pick = 64'($urandom_range(MAX_ORDER_LEN + 1, 63));
                    default: len_pick = 64'($urandom_range(2, MAX_ORDER_LEN - 1));
                endcase
                case ($urandom_range(0, 5))
                    0:       budget_pick = 64'd0;
                    1:       budget_pick = 64'd1;
                    2:       budget_pick = 64'($urandom_range(2, 40));
                    3:       budget_pick = 64'(FLOW_CAP);
                    4:       budget_pick = 64'($urandom_range(FLOW_CAP + 1, 2047));
                    default: budget_pick = 64'($urandom_range(41, 400));
                endcase
                if (phase == 1)
                    budget_pick = 64'd400;
            end
            cfg_write(CFG_FLOW_ORDER, order_pick);
            cfg_write(CFG_FLOW_ORDER_LEN, len_pick);
            cfg_write(CFG_NUM_FLOWS, budget_pick);
            calm = (phase % 3 == 2);

            if (phase == 0)
            begin
                // alternate A and T so each pair walks one whole cycle
                for (k = 0; k < SWEEP_BASES; k++)
                    send_base((k % 2 == 0) ? NUC_A : NUC_T, k == SWEEP_BASES - 1, 1'b0, '0);
            end
            else if (phase == 1)
            begin
                // run one nucleotide long enough to saturate the count
                b = nuc_at($urandom_range(0, order_span() - 1));
                for (k = 0; k < HOMOPOLYMER; k++)
                    send_base(b, k == HOMOPOLYMER - 1, 1'b0, '0);
            end
            else
            begin
                start = live_bases;
                while (live_bases - start < PHASE_BASES)
                    send_random_read();
            end
            phase++;
        end

        settle();
        if (errors == 0)
            $display("base_to_flowgram_converter_top regression: pass");
        else
            $display("base_to_flowgram_converter_top regression: fail");
        $finish;
    end

endmodule
